[sv/assert_macros.svh]
// Assertion macros used by the varint decoder back end.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/bvd_pkg.sv]
// Shared types, status codes and width limits for the base-128 varint decoder.
// No dependencies.
`timescale 1ns / 1ps

package bvd_pkg;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_MALFORMED  = 2'd1;
  localparam status_t ST_INCOMPLETE = 2'd2;

  // Target width codes
  typedef logic [1:0] width_t;
  localparam width_t W_8  = 2'd0;
  localparam width_t W_16 = 2'd1;
  localparam width_t W_32 = 2'd2;
  localparam width_t W_64 = 2'd3;

  // Queue depths
  localparam int ItemQDepth = 4;
  localparam int ResQDepth  = 2;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [6:0] payload;   // low seven bits of the byte
    width_t     width;     // width latched for this value
    logic       first;     // first byte of a value
    logic       last_ok;   // last permitted byte for this width
    logic       terminal;  // bit 7 clear
    logic       eod;       // end of data flag
    logic [3:0] used;      // bytes of this value including this one
  } bvd_item_t;

  // One result item
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic [3:0]  used;
  } bvd_result_t;

  // Byte limit per target width
  function automatic logic [3:0] limit_bytes(input width_t w);
    logic [3:0] lim;
    case (w)
      W_8:     lim = 4'd2;
      W_16:    lim = 4'd3;
      W_32:    lim = 4'd5;
      W_64:    lim = 4'd10;
      default: lim = 4'd10;
    endcase
    return lim;
  endfunction

endpackage

[sv/bvd_front.sv]
// Front end: accepts stream bytes, tracks value position and classifies bytes.
// Classified bytes are held in a four-entry queue for the back end. Uses bvd_pkg.
`timescale 1ns / 1ps

module bvd_front
  import bvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  input  logic [1:0] in_mode,
  input  logic       in_end_of_data,
  output logic       in_full,
  output logic       item_valid,
  output bvd_item_t  item,
  input  logic       item_take
);

  localparam int PtrW = $clog2(ItemQDepth);
  localparam int CntW = $clog2(ItemQDepth + 1);

  logic [3:0]      pos_r, pos_nxt;
  width_t          wl_r, wl_nxt;
  bvd_item_t       q_mem_r [ItemQDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            acc_in, ends;
  width_t          w_cur;
  bvd_item_t       cls;

  assign in_full    = (cnt_r == CntW'(ItemQDepth));
  assign acc_in     = in_push && !in_full;
  assign item_valid = (cnt_r != '0);
  assign item       = q_mem_r[rd_ptr_r];

  // Classify the incoming byte against the current value position
  always_comb begin
    w_cur         = (pos_r == 4'd0) ? width_t'(in_mode) : wl_r;
    cls.payload   = in_data_byte[6:0];
    cls.width     = w_cur;
    cls.first     = (pos_r == 4'd0);
    cls.used      = pos_r + 4'd1;
    cls.last_ok   = (cls.used >= limit_bytes(w_cur));
    cls.terminal  = !in_data_byte[7];
    cls.eod       = in_end_of_data;
    ends          = cls.terminal || cls.last_ok || cls.eod;
    pos_nxt       = ends ? 4'd0 : cls.used;
    wl_nxt        = ends ? W_8 : w_cur;
  end

  // Position tracking and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 4'd0;
      wl_r     <= W_8;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (acc_in) begin
        pos_r    <= pos_nxt;
        wl_r     <= wl_nxt;
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (item_take && item_valid) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r <= cnt_r + CntW'(acc_in) - CntW'(item_take && item_valid);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (acc_in) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[sv/bvd_back.sv]
// Back end: accumulates seven-bit groups, checks range and overflow, and queues
// results in a two-entry output queue. Uses bvd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvd_back
  import bvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  bvd_item_t   item,
  output logic        item_take,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_decoded_value,
  output logic [1:0]  out_status,
  output logic [3:0]  out_bytes_used
);

  localparam int PtrW = $clog2(ResQDepth);
  localparam int CntW = $clog2(ResQDepth + 1);

  logic [63:0]     acc_r, acc_nxt, acc_base;
  bvd_result_t     oq_mem_r [ResQDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            oq_full, oq_pop, res_valid, ovf;
  bvd_result_t     res;

  assign oq_full   = (cnt_r == CntW'(ResQDepth));
  assign item_take = item_valid && !oq_full;
  assign out_empty = (cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;

  assign out_decoded_value = oq_mem_r[rd_ptr_r].value;
  assign out_status        = oq_mem_r[rd_ptr_r].status;
  assign out_bytes_used    = oq_mem_r[rd_ptr_r].used;

  // Accumulate and decide the outcome of this byte
  always_comb begin
    acc_base = item.first ? 64'd0 : acc_r;
    ovf      = item.last_ok &&
               (((item.width == W_32) && (acc_base[63:25] != '0)) ||
                ((item.width == W_64) && (acc_base[63:57] != '0)));
    acc_nxt  = {acc_base[56:0], item.payload};
    if (item.width == W_32) begin
      acc_nxt[63:32] = 32'd0;
    end
    res_valid  = 1'b1;
    res.used   = item.used;
    res.value  = 64'd0;
    res.status = ST_MALFORMED;
    if (ovf) begin
      res.status = ST_MALFORMED;
    end else if (item.terminal) begin
      if (((item.width == W_8) && (acc_nxt[63:8] != '0)) ||
          ((item.width == W_16) && (acc_nxt[63:16] != '0))) begin
        res.status = ST_MALFORMED;
      end else begin
        res.status = ST_OK;
        res.value  = acc_nxt;
      end
    end else if (item.last_ok) begin
      res.status = ST_MALFORMED;
    end else if (item.eod) begin
      res.status = ST_INCOMPLETE;
    end else begin
      res_valid = 1'b0;
    end
  end

  // Accumulator keeps the partial value between bytes
  always_ff @(posedge clk) begin
    if (item_take) begin
      acc_r <= acc_nxt;
    end
  end

  // Output queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (item_take && res_valid) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (oq_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r <= cnt_r + CntW'(item_take && res_valid) - CntW'(oq_pop);
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (item_take && res_valid) begin
      oq_mem_r[wr_ptr_r] <= res;
    end
  end

  `ASSERT_NEVER(a_err_value_zero, item_take && res_valid && (res.status != ST_OK) && (res.value != 64'd0), "error result carries a value")
  `ASSERT_NEVER(a_used_range, item_take && res_valid && ((res.used == 4'd0) || (res.used > 4'd10)), "bytes used out of range")
  `ASSERT_CLK(a_oq_count, (item_take && res_valid && !oq_pop) |=> (cnt_r == $past(cnt_r) + CntW'(1)), "output queue count did not grow")

endmodule

[sv/base128_varint_decoder.sv]
// Base-128 varint decoder, most significant group first, one byte per cycle.
// Path: an accepted byte is registered in the front queue, then its result (if any) in the output queue.
// Throughput: one byte per cycle while in_full is low; a full output queue stalls the front queue.
// Queues: four classified bytes between front and back, two results at the output.
// Reset: synchronous active-low rst_n empties both queues and idles the decoder.
`timescale 1ns / 1ps

module base128_varint_decoder
  import bvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_mode,
  input  logic        in_end_of_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_decoded_value,
  output logic [1:0]  out_status,
  output logic [3:0]  out_bytes_used
);

  logic      item_valid, item_take;
  bvd_item_t item;

  // Accept and classify bytes
  bvd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_data_byte   (in_data_byte),
    .in_mode        (in_mode),
    .in_end_of_data (in_end_of_data),
    .in_full        (in_full),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take)
  );

  // Accumulate and report
  bvd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item              (item),
    .item_take         (item_take),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_decoded_value (out_decoded_value),
    .out_status        (out_status),
    .out_bytes_used    (out_bytes_used)
  );

endmodule
